>>> rtl/e131_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the E1.31 data packet framer.
// No dependencies; used by every module under rtl/.
package e131_pkg;

  // input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PAIR  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_CID_HIGH = 3'd0;
  localparam logic [2:0] REG_CID_LOW  = 3'd1;
  localparam logic [2:0] REG_PRIORITY = 3'd2;
  localparam logic [2:0] REG_NAME_0   = 3'd3;
  localparam logic [2:0] REG_NAME_1   = 3'd4;
  localparam logic [2:0] REG_NAME_2   = 3'd5;
  localparam logic [2:0] REG_NAME_3   = 3'd6;
  localparam logic [2:0] REG_NAME_4   = 3'd7;

  localparam logic [7:0] PRIORITY_RESET = 8'd100;

  // header: 126 bytes = 63 words, index 0..62
  localparam logic [5:0] HDR_LAST = 6'd62;

  typedef struct packed {
    logic [127:0] cid;
    logic [319:0] name;
    logic [7:0]   prio;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [15:0] universe;
  } seq_req_t;

  typedef struct packed {
    logic       ready;
    logic [7:0] seq;
  } seq_stat_t;

endpackage

>>> rtl/e131_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: CID, source priority and source name.
// Depends on e131_pkg.
module e131_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [2:0]         index,
  input  logic [63:0]        data,
  output e131_pkg::cfg_t     cfg
);

  e131_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.cid  <= '0;
      regs.name <= '0;
      regs.prio <= e131_pkg::PRIORITY_RESET;
    end else if (we) begin
      unique case (index)
        e131_pkg::REG_CID_HIGH: regs.cid[127:64]  <= data;
        e131_pkg::REG_CID_LOW:  regs.cid[63:0]    <= data;
        e131_pkg::REG_PRIORITY: regs.prio         <= data[7:0];
        e131_pkg::REG_NAME_0:   regs.name[319:256] <= data;
        e131_pkg::REG_NAME_1:   regs.name[255:192] <= data;
        e131_pkg::REG_NAME_2:   regs.name[191:128] <= data;
        e131_pkg::REG_NAME_3:   regs.name[127:64]  <= data;
        e131_pkg::REG_NAME_4:   regs.name[63:0]    <= data;
      endcase
    end
  end

  assign cfg = regs;

endmodule

>>> rtl/e131_seq_table.sv
`timescale 1ns / 1ps
// Per-universe sequence number memory with read-increment-write and a
// clearing sweep after reset. Depends on e131_pkg.
module e131_seq_table #(
  parameter int ADDR_BITS = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  e131_pkg::seq_req_t    req,
  output e131_pkg::seq_stat_t   stat
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [7:0]           mem [DEPTH];
  logic                 clearing;
  logic [ADDR_BITS-1:0] clr_addr;
  logic [7:0]           rd_data;
  logic                 wb_pend;
  logic [ADDR_BITS-1:0] wb_addr;
  logic [7:0]           seq_hold;
  logic [ADDR_BITS-1:0] rd_addr;

  assign rd_addr = req.universe[ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      wb_pend  <= 1'b0;
    end else begin
      wb_pend <= req.start;
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_BITS'(1);
        if (&clr_addr) clearing <= 1'b0;
      end
    end
  end

  // one read port, one write port; write-back lands the cycle after the read
  always_ff @(posedge clk) begin
    if (req.start) begin
      rd_data <= mem[rd_addr];
      wb_addr <= rd_addr;
    end
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (wb_pend) begin
      mem[wb_addr] <= rd_data + 8'd1;
    end
    if (wb_pend) seq_hold <= rd_data;
  end

  assign stat.ready = !clearing;
  assign stat.seq   = seq_hold;

  a_no_read_in_clear: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !clearing)
    else $error("sequence read during clearing sweep");

  a_no_read_on_wb: assert property (@(posedge clk) disable iff (rst)
    wb_pend |-> !req.start)
    else $error("sequence read overlaps write-back");

  a_wb_follows_read: assert property (@(posedge clk) disable iff (rst)
    req.start |=> wb_pend)
    else $error("write-back missing after read");

endmodule

>>> rtl/e131_hdr_mux.sv
`timescale 1ns / 1ps
// Header word assembler: constant template merged with CID, name, priority,
// sequence and universe fields. Depends on e131_pkg.
module e131_hdr_mux (
  input  logic [5:0]      idx,
  input  e131_pkg::cfg_t  cfg,
  input  logic [7:0]      seq,
  input  logic [15:0]     universe,
  output logic [15:0]     word
);

  localparam logic [5:0] CID_W0  = 6'd11;
  localparam logic [5:0] CID_WN  = 6'd18;
  localparam logic [5:0] NAME_W0 = 6'd22;
  localparam logic [5:0] NAME_WN = 6'd41;
  localparam logic [5:0] PRIO_W  = 6'd54;
  localparam logic [5:0] SEQ_W   = 6'd55;
  localparam logic [5:0] UNI_HI_W = 6'd56;
  localparam logic [5:0] UNI_LO_W = 6'd57;

  function automatic logic [15:0] template_word(input logic [5:0] i);
    logic [15:0] w;
    unique case (i)
      6'd0:  w = 16'h0010;   // preamble size
      6'd2:  w = 16'h4153;   // "AS"
      6'd3:  w = 16'h432D;   // "C-"
      6'd4:  w = 16'h4531;   // "E1"
      6'd5:  w = 16'h2E31;   // ".1"
      6'd6:  w = 16'h3700;   // "7", NUL pad
      6'd8:  w = 16'h726E;   // root flags and length
      6'd10: w = 16'h0004;   // root vector
      6'd19: w = 16'h7258;   // framing flags and length
      6'd21: w = 16'h0002;   // framing vector
      6'd58: w = 16'h0B02;   // DMP length low, vector
      6'd59: w = 16'hA100;   // address type, first address high
      6'd61: w = 16'h0102;   // increment low, count high
      6'd62: w = 16'h0100;   // count low, start code
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

  logic [15:0] cid_w  [8];
  logic [15:0] name_w [20];
  logic [2:0]  cid_k;
  logic [4:0]  name_k;

  for (genvar i = 0; i < 8; i++) begin : g_cid
    assign cid_w[i] = cfg.cid[127-16*i -: 16];
  end
  for (genvar i = 0; i < 20; i++) begin : g_name
    assign name_w[i] = cfg.name[319-16*i -: 16];
  end

  assign cid_k  = 3'(idx - CID_W0);
  assign name_k = 5'(idx - NAME_W0);

  always_comb begin
    priority if (idx >= CID_W0 && idx <= CID_WN)   word = cid_w[cid_k];
    else if (idx >= NAME_W0 && idx <= NAME_WN)     word = name_w[name_k];
    else if (idx == PRIO_W)                        word = {cfg.prio, 8'h00};
    else if (idx == SEQ_W)                         word = {8'h00, seq};
    else if (idx == UNI_HI_W)                      word = {8'h00, universe[15:8]};
    else if (idx == UNI_LO_W)                      word = {universe[7:0], 8'h72};
    else                                           word = template_word(idx);
  end

endmodule

>>> rtl/e131_data_packet_framer_core.sv
`timescale 1ns / 1ps
// E1.31 data packet framer, top level. Depends on e131_pkg, e131_cfg_regs,
// e131_seq_table and e131_hdr_mux.
// Output is registered: a result is in the output register the cycle after its request is accepted.
// Throughput: one word per cycle while the output is not stalled; a start request
//   holds the input while its 63 header words go out, and a slot pair gives one word.
// Reset: synchronous; afterwards all 2**UNIVERSE_BITS entries of the sequence table
//   are swept to zero with in_ready low (config writes still taken).
module e131_data_packet_framer_core #(
  parameter int UNIVERSE_BITS = 9
) (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] universe,
  input  logic [7:0]  slot_even,
  input  logic [7:0]  slot_odd,
  // packet words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] packet_word,
  output logic        packet_end
);

  e131_pkg::cfg_t      cfg;
  e131_pkg::seq_req_t  seq_req;
  e131_pkg::seq_stat_t seq_stat;

  // header walk state
  logic        hdr_busy;
  logic [5:0]  hdr_idx;
  logic [15:0] uni_q;
  // packet state
  logic        packet_open;
  logic [7:0]  pairs_sent;

  logic        advance;
  logic        accept;
  logic        start_acc;
  logic        pair_emit;
  logic        hdr_step;
  logic [5:0]  mux_idx;
  logic [15:0] hdr_word;

  e131_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  e131_seq_table #(.ADDR_BITS(UNIVERSE_BITS)) u_seq (
    .clk  (clk),
    .rst  (rst),
    .req  (seq_req),
    .stat (seq_stat)
  );

  // Word 0 goes out at the accept edge; words 1..62 follow one per cycle while the output is not stalled.
  // The sequence byte (word 55) is read at accept, so it is long settled.
  assign mux_idx = hdr_busy ? hdr_idx : 6'd0;

  e131_hdr_mux u_hdr (
    .idx      (mux_idx),
    .cfg      (cfg),
    .seq      (seq_stat.seq),
    .universe (uni_q),
    .word     (hdr_word)
  );

  // output register frees up when empty or being drained
  assign advance   = !out_valid || out_ready;
  assign in_ready  = seq_stat.ready && !hdr_busy && advance;
  assign accept    = in_valid && in_ready;
  assign start_acc = accept && (kind == e131_pkg::KIND_START);
  assign pair_emit = accept && (kind == e131_pkg::KIND_PAIR) && packet_open;
  assign hdr_step  = hdr_busy && advance;

  assign seq_req.start    = start_acc;
  assign seq_req.universe = universe;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_busy    <= 1'b0;
      hdr_idx     <= 6'd0;
      packet_open <= 1'b0;
      pairs_sent  <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      if (start_acc) begin
        hdr_busy    <= 1'b1;
        hdr_idx     <= 6'd1;
        packet_open <= 1'b1;   // abandons any open packet
        pairs_sent  <= 8'd0;
      end else if (hdr_step) begin
        hdr_idx <= hdr_idx + 6'd1;
        if (hdr_idx == e131_pkg::HDR_LAST) hdr_busy <= 1'b0;
      end else if (pair_emit) begin
        pairs_sent <= pairs_sent + 8'd1;  // wraps to zero after the 256th
        if (&pairs_sent) packet_open <= 1'b0;
      end

      if (hdr_step || start_acc || pair_emit) out_valid <= 1'b1;
      else if (out_ready)                     out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_acc) uni_q <= universe;
    if (hdr_step || start_acc) begin
      packet_word <= hdr_word;
      packet_end  <= 1'b0;
    end else if (pair_emit) begin
      packet_word <= {slot_even, slot_odd};
      packet_end  <= &pairs_sent;
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    hdr_busy |-> !in_ready)
    else $error("input accepted during header walk");

  a_busy_idx_nonzero: assert property (@(posedge clk) disable iff (rst)
    hdr_busy |-> hdr_idx != 6'd0)
    else $error("header index zero while walking");

  a_end_closes_packet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && packet_end) |-> (!packet_open && !hdr_busy))
    else $error("end word shown while a packet is open");

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    start_acc |=> (packet_open && hdr_busy && out_valid))
    else $error("start request did not open a packet");

endmodule
